@@ design/apswr_pkg.sv @@
// ----------------------------------------------------------------------------
// apswr_pkg: shared types and constants
// Config register layout, reset values, queue control word, step codes and
// the screen size clamp used by the front and back ends.
// ----------------------------------------------------------------------------
package apswr_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int SIZE_BITS      = 13;
	localparam int POS_BITS       = 12;
	localparam int ACC_BITS       = 24;
	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_IDX_BITS   = 2;
	localparam int QUEUE_DEPTH    = 2;
	localparam int DIV_CNT_BITS   = 4;

	localparam int ACC_MAX = 8388607;
	localparam int ACC_MIN = -8388608;

	localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = 13'd4096;

	localparam logic [SIZE_BITS-1:0] RST_SCREEN_W = 13'd640;
	localparam logic [SIZE_BITS-1:0] RST_SCREEN_H = 13'd480;
	localparam logic [7:0]           RST_DETENT   = 8'd8;
	localparam logic [7:0]           RST_SCROLL   = 8'd40;
	localparam logic [POS_BITS-1:0]  RST_X        = POS_BITS'(640 / 2);
	localparam logic [POS_BITS-1:0]  RST_Y        = POS_BITS'(480 / 2);

	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_W = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_H = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DETENT   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCROLL   = 2'd3;

	localparam logic [1:0] STEP_NONE = 2'b00;
	localparam logic [1:0] STEP_POS  = 2'b01;
	localparam logic [1:0] STEP_NEG  = 2'b11;

	typedef struct packed {
		logic [SIZE_BITS-1:0] screen_width;
		logic [SIZE_BITS-1:0] screen_height;
		logic [7:0]           counts_per_detent;
		logic [7:0]           scroll_pixels;
	} cfg_t;

	typedef struct packed {
		logic absent;
		logic fresh;
		logic btn0;
		logic sat_x;
		logic sat_y;
	} fr_ctl_t;

	function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
		logic [SIZE_BITS-1:0] r;
		r = s;
		if (s == '0)
			r = SIZE_BITS'(1);
		else if (s > SIZE_LIMIT)
			r = SIZE_LIMIT;
		return r;
	endfunction

endpackage

@@ design/apswr_front.sv @@
// ----------------------------------------------------------------------------
// apswr_front: report classifier
// Flags absent or invalid ranges, forms axis ranges, saturation flags and
// scaled numerators for the back end.
// ----------------------------------------------------------------------------
module apswr_front import apswr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  cfg_t                            cfg,
	input  logic                            device_present,
	input  logic                            report_fresh,
	input  logic [COORD_BITS-1:0]           abs_x,
	input  logic [COORD_BITS-1:0]           abs_y,
	input  logic [7:0]                      buttons,
	input  logic [COORD_BITS-1:0]           min_x,
	input  logic [COORD_BITS-1:0]           max_x,
	input  logic [COORD_BITS-1:0]           min_y,
	input  logic [COORD_BITS-1:0]           max_y,
	output fr_ctl_t                         ctl,
	output logic [COORD_BITS+SIZE_BITS-1:0] num_x,
	output logic [COORD_BITS-1:0]           den_x,
	output logic [COORD_BITS+SIZE_BITS-1:0] num_y,
	output logic [COORD_BITS-1:0]           den_y
);

	localparam int NUM_W = COORD_BITS + SIZE_BITS;

	logic [SIZE_BITS-1:0] size_w;
	logic [SIZE_BITS-1:0] size_h;

	always_comb begin
		size_w = eff_size(cfg.screen_width);
		size_h = eff_size(cfg.screen_height);
		den_x = max_x - min_x;
		den_y = max_y - min_y;
		num_x = NUM_W'(abs_x) * NUM_W'(size_w);
		num_y = NUM_W'(abs_y) * NUM_W'(size_h);
		ctl.absent = !device_present || (max_x == '0) || (max_y == '0)
			|| (min_x >= max_x) || (min_y >= max_y);
		ctl.fresh = report_fresh;
		ctl.btn0 = buttons[0];
		ctl.sat_x = abs_x >= den_x;
		ctl.sat_y = abs_y >= den_y;
	end

endmodule

@@ design/apswr_queue.sv @@
// ----------------------------------------------------------------------------
// apswr_queue: command queue
// Short FIFO between the classifier and the back end.
// ----------------------------------------------------------------------------
module apswr_queue import apswr_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign valid   = cnt_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ design/apswr_div.sv @@
// ----------------------------------------------------------------------------
// apswr_div: serial divider
// Restoring divider, one quotient bit per cycle; the quotient is known to
// fit in SIZE_BITS bits.
// ----------------------------------------------------------------------------
module apswr_div import apswr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [COORD_BITS+SIZE_BITS-1:0] num,
	input  logic [COORD_BITS-1:0]           den,
	output logic                            done,
	output logic [SIZE_BITS-1:0]            quo
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [COORD_BITS-1:0]   rem_q;
	logic [COORD_BITS-1:0]   den_q;
	logic [SIZE_BITS-1:0]    lo_q;
	logic [SIZE_BITS-1:0]    quo_q;
	logic [COORD_BITS:0]     trial;
	logic [COORD_BITS:0]     diff;
	logic                    ge;

	assign done = done_q;
	assign quo  = quo_q;

	always_comb begin
		trial = {rem_q, lo_q[SIZE_BITS-1]};
		diff = trial - {1'b0, den_q};
		ge = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(SIZE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[COORD_BITS+SIZE_BITS-1:SIZE_BITS];
			lo_q <= num[SIZE_BITS-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			lo_q <= {lo_q[SIZE_BITS-2:0], 1'b0};
			quo_q <= {quo_q[SIZE_BITS-2:0], ge};
		end
	end

endmodule

@@ design/apswr_back.sv @@
// ----------------------------------------------------------------------------
// apswr_back: position, button and wheel engine
// Pops classified reports, divides both axes of fresh present reports on a
// shared divider, updates pointer and wheel state and holds the result word
// for the output side.
module apswr_back import apswr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cfg_t                            cfg,
	input  logic                            q_valid,
	input  fr_ctl_t                         q_ctl,
	input  logic [COORD_BITS-1:0]           q_az,
	input  logic [COORD_BITS+SIZE_BITS-1:0] q_num_x,
	input  logic [COORD_BITS-1:0]           q_den_x,
	input  logic [COORD_BITS+SIZE_BITS-1:0] q_num_y,
	input  logic [COORD_BITS-1:0]           q_den_y,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [POS_BITS-1:0]             cursor_x,
	output logic [POS_BITS-1:0]             cursor_y,
	output logic                            pressed,
	output logic signed [1:0]               detent_step,
	output logic signed [8:0]               scroll_amount,
	output logic                            cursor_shown
);

	localparam int NUM_W = COORD_BITS + SIZE_BITS;
	localparam int SUM_W = ((COORD_BITS + 1 > ACC_BITS) ? COORD_BITS + 1 : ACC_BITS) + 1;
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(ACC_MAX);
	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(ACC_MIN);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIVX  = 4'b0010,
		ST_DIVY  = 4'b0100,
		ST_WRITE = 4'b1000
	} bk_state_t;

	bk_state_t state_q;

	fr_ctl_t                ctl_q;
	logic [COORD_BITS-1:0]  az_q;
	logic [NUM_W-1:0]       num_y_q;
	logic [COORD_BITS-1:0]  den_y_q;
	logic [POS_BITS-1:0]    qx_q;
	logic [POS_BITS-1:0]    qy_q;

	logic [POS_BITS-1:0]        last_x_q;
	logic [POS_BITS-1:0]        last_y_q;
	logic [COORD_BITS-1:0]      last_w_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic                       held_q;
	logic                       vis_q;

	logic                    out_valid_q;
	logic [POS_BITS-1:0]     cursor_x_q;
	logic [POS_BITS-1:0]     cursor_y_q;
	logic                    pressed_q;
	logic [1:0]              step_q;
	logic [8:0]              amount_q;
	logic                    shown_q;

	logic                   div_start;
	logic [NUM_W-1:0]       div_num;
	logic [COORD_BITS-1:0]  div_den;
	logic                   div_done;
	logic [SIZE_BITS-1:0]   div_quo;

	logic [POS_BITS-1:0] wmax;
	logic [POS_BITS-1:0] hmax;
	logic                fire;

	logic [POS_BITS-1:0]        nx;
	logic [POS_BITS-1:0]        ny;
	logic                       nheld;
	logic                       nvis;
	logic signed [COORD_BITS:0] dlt;
	logic signed [SUM_W-1:0]    sum;
	logic signed [ACC_BITS-1:0] acc_mid;
	logic signed [ACC_BITS-1:0] acc_base;
	logic signed [ACC_BITS-1:0] det_w;
	logic signed [ACC_BITS-1:0] acc_next;
	logic [7:0]                 det8;
	logic [1:0]                 nstep;
	logic signed [8:0]          sp9;
	logic signed [8:0]          namount;

	apswr_div #(
		.COORD_BITS(COORD_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign fire  = (state_q == ST_WRITE) && (!out_valid_q || !out_stall);
	assign wmax  = POS_BITS'(eff_size(cfg.screen_width) - 1'b1);
	assign hmax  = POS_BITS'(eff_size(cfg.screen_height) - 1'b1);

	always_comb begin
		div_start = (q_pop && !q_ctl.absent && q_ctl.fresh)
			|| ((state_q == ST_DIVX) && div_done);
		div_num = (state_q == ST_IDLE) ? q_num_x : num_y_q;
		div_den = (state_q == ST_IDLE) ? q_den_x : den_y_q;
	end

	always_comb begin
		nx = ctl_q.fresh ? qx_q : last_x_q;
		ny = ctl_q.fresh ? qy_q : last_y_q;
		nheld = ctl_q.fresh ? ctl_q.btn0 : held_q;
		nvis = vis_q || (ctl_q.fresh
			&& ((qx_q != last_x_q) || (qy_q != last_y_q) || ctl_q.btn0));
		dlt = $signed({1'b0, az_q}) - $signed({1'b0, last_w_q});
		sum = SUM_W'(acc_q) + SUM_W'(dlt);
		if (sum > SUM_HI)
			acc_mid = ACC_BITS'(ACC_MAX);
		else if (sum < SUM_LO)
			acc_mid = ACC_BITS'(ACC_MIN);
		else
			acc_mid = sum[ACC_BITS-1:0];
		acc_base = ctl_q.fresh ? acc_mid : acc_q;
		det8 = (cfg.counts_per_detent == '0) ? 8'd1 : cfg.counts_per_detent;
		det_w = {{(ACC_BITS-8){1'b0}}, det8};
		if (acc_base >= det_w) begin
			nstep = STEP_POS;
			acc_next = acc_base - det_w;
		end else if (acc_base <= -det_w) begin
			nstep = STEP_NEG;
			acc_next = acc_base + det_w;
		end else begin
			nstep = STEP_NONE;
			acc_next = acc_base;
		end
		sp9 = $signed({1'b0, cfg.scroll_pixels});
		case (nstep)
			STEP_POS: namount = sp9;
			STEP_NEG: namount = -sp9;
			default:  namount = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= (!q_ctl.absent && q_ctl.fresh) ? ST_DIVX : ST_WRITE;
				end
				ST_DIVX: begin
					if (div_done)
						state_q <= ST_DIVY;
				end
				ST_DIVY: begin
					if (div_done)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q <= q_ctl;
			az_q <= q_az;
			num_y_q <= q_num_y;
			den_y_q <= q_den_y;
		end
		if ((state_q == ST_DIVX) && div_done)
			qx_q <= ctl_q.sat_x ? wmax : div_quo[POS_BITS-1:0];
		if ((state_q == ST_DIVY) && div_done)
			qy_q <= ctl_q.sat_y ? hmax : div_quo[POS_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= RST_X;
			last_y_q <= RST_Y;
			last_w_q <= '0;
			acc_q <= '0;
			held_q <= 1'b0;
			vis_q <= 1'b0;
		end else if (fire) begin
			if (ctl_q.absent) begin
				vis_q <= 1'b0;
			end else begin
				last_x_q <= nx;
				last_y_q <= ny;
				held_q <= nheld;
				vis_q <= nvis;
				acc_q <= acc_next;
				if (ctl_q.fresh)
					last_w_q <= az_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (ctl_q.absent) begin
				cursor_x_q <= last_x_q;
				cursor_y_q <= last_y_q;
				pressed_q <= 1'b0;
				step_q <= STEP_NONE;
				amount_q <= '0;
				shown_q <= 1'b0;
			end else begin
				cursor_x_q <= nx;
				cursor_y_q <= ny;
				pressed_q <= nheld;
				step_q <= nstep;
				amount_q <= namount;
				shown_q <= nvis;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_x      = cursor_x_q;
	assign cursor_y      = cursor_y_q;
	assign pressed       = pressed_q;
	assign detent_step   = $signed(step_q);
	assign scroll_amount = $signed(amount_q);
	assign cursor_shown  = shown_q;

endmodule

@@ design/absolute_pointer_scaler_wheel_ratchet_unit.sv @@
// ----------------------------------------------------------------------------
// absolute_pointer_scaler_wheel_ratchet_unit: pointer scaler top level
// Maps absolute pointer reports to screen pixels, latches the left button,
// tracks cursor visibility and ratchets wheel counts into scroll steps.
//
//   channel  direction  handshake             payload
//   report   input      in_valid / in_stall   device_present .. max_y, one report per word
//   result   output     out_valid / out_stall cursor_x .. cursor_shown, one result per word
//   config   input      cfg_write             cfg_index, cfg_data, no wait
//
// A fresh, valid report goes from its pop at the queue head to the result register
// through the pop in ST_IDLE, two passes (x, then y) through the shared serial
// divider, each closed by a done pulse, and ST_WRITE, which waits out an output stall.
// Stale or absent reports skip the divider; the queue registers each word it accepts.
// Reset is asynchronous; config and pointer state load their defaults at once.
// Two words queue between classifier and engine; in_stall rises when full.
// ----------------------------------------------------------------------------
module absolute_pointer_scaler_wheel_ratchet_unit import apswr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     device_present,
	input  logic                     report_fresh,
	input  logic [COORD_BITS-1:0]    abs_x,
	input  logic [COORD_BITS-1:0]    abs_y,
	input  logic [COORD_BITS-1:0]    abs_z,
	input  logic [7:0]               buttons,
	input  logic [COORD_BITS-1:0]    min_x,
	input  logic [COORD_BITS-1:0]    max_x,
	input  logic [COORD_BITS-1:0]    min_y,
	input  logic [COORD_BITS-1:0]    max_y,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [POS_BITS-1:0]      cursor_x,
	output logic [POS_BITS-1:0]      cursor_y,
	output logic                     pressed,
	output logic signed [1:0]        detent_step,
	output logic signed [8:0]        scroll_amount,
	output logic                     cursor_shown
);

	localparam int NUM_W = COORD_BITS + SIZE_BITS;
	localparam int CTL_W = $bits(fr_ctl_t);
	localparam int Q_W   = CTL_W + COORD_BITS + 2 * NUM_W + 2 * COORD_BITS;

	cfg_t cfg_q;

	fr_ctl_t               fr_ctl;
	logic [NUM_W-1:0]      fr_num_x;
	logic [COORD_BITS-1:0] fr_den_x;
	logic [NUM_W-1:0]      fr_num_y;
	logic [COORD_BITS-1:0] fr_den_y;

	logic [Q_W-1:0] q_in;
	logic [Q_W-1:0] q_head;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;

	fr_ctl_t               hd_ctl;
	logic [COORD_BITS-1:0] hd_az;
	logic [NUM_W-1:0]      hd_num_x;
	logic [COORD_BITS-1:0] hd_den_x;
	logic [NUM_W-1:0]      hd_num_y;
	logic [COORD_BITS-1:0] hd_den_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= RST_SCREEN_W;
			cfg_q.screen_height <= RST_SCREEN_H;
			cfg_q.counts_per_detent <= RST_DETENT;
			cfg_q.scroll_pixels <= RST_SCROLL;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SCREEN_W: cfg_q.screen_width <= cfg_data;
				REG_SCREEN_H: cfg_q.screen_height <= cfg_data;
				REG_DETENT:   cfg_q.counts_per_detent <= cfg_data[7:0];
				REG_SCROLL:   cfg_q.scroll_pixels <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	apswr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.cfg(cfg_q),
		.device_present(device_present),
		.report_fresh(report_fresh),
		.abs_x(abs_x),
		.abs_y(abs_y),
		.buttons(buttons),
		.min_x(min_x),
		.max_x(max_x),
		.min_y(min_y),
		.max_y(max_y),
		.ctl(fr_ctl),
		.num_x(fr_num_x),
		.den_x(fr_den_x),
		.num_y(fr_num_y),
		.den_y(fr_den_y)
	);

	assign q_in = {fr_ctl, abs_z, fr_num_x, fr_den_x, fr_num_y, fr_den_y};
	assign {hd_ctl, hd_az, hd_num_x, hd_den_x, hd_num_y, hd_den_y} = q_head;
	assign in_stall = q_full;

	apswr_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid),
		.push_data(q_in),
		.pop(q_pop),
		.full(q_full),
		.valid(q_valid),
		.head(q_head)
	);

	apswr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_ctl(hd_ctl),
		.q_az(hd_az),
		.q_num_x(hd_num_x),
		.q_den_x(hd_den_x),
		.q_num_y(hd_num_y),
		.q_den_y(hd_den_y),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cursor_x(cursor_x),
		.cursor_y(cursor_y),
		.pressed(pressed),
		.detent_step(detent_step),
		.scroll_amount(scroll_amount),
		.cursor_shown(cursor_shown)
	);

	a_no_step_no_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (detent_step == STEP_NONE) |-> (scroll_amount == '0))
		else $error("scroll amount without wheel step");

	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (detent_step == STEP_NONE) || (detent_step == STEP_POS)
			|| (detent_step == STEP_NEG))
		else $error("wheel step out of range");

	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_valid)
		else $error("input stalled with empty queue");

	a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
